>>> rtl/mhif_pkg.sv
// Shared types and constants for the max-heap insert/find core.
`timescale 1ns / 1ps

package mhif_pkg;

	localparam int KEY_W          = 32;
	localparam int CAP_W          = 6;
	localparam int HEAP_DEPTH_DEF = 32;
	localparam logic [CAP_W-1:0] CAP_RESET = 6'd32;

	// Command codes on the input word
	typedef enum logic [1:0] {
		CMD_INSERT = 2'd0,
		CMD_FIND   = 2'd1,
		CMD_DUMP   = 2'd2
	} cmd_t;

	// Status codes on the result word
	typedef enum logic [2:0] {
		ST_INSERTED = 3'd0,
		ST_FULL     = 3'd1,
		ST_DUP      = 3'd2,
		ST_FOUND    = 3'd3,
		ST_MISSING  = 3'd4,
		ST_ELEM     = 3'd5,
		ST_EMPTY    = 3'd6
	} status_t;

	// Sequencer states
	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_SIFT_RD,
		S_SIFT_CMP,
		S_DUMP_RD,
		S_DUMP_OUT,
		S_RESP
	} state_t;

endpackage

>>> rtl/max_heap_insert_find_core.sv
// Max-heap of signed keys with insert, find and dump, built around one heap memory.
// Operation: find scans the stored slots in order and stops at the first match; insert scans
//   the same way, then sifts the new key up past smaller parents until it reaches the root or a
//   parent that is not smaller; dump reads out every stored key in slot order.
// Throughput: one command word at a time, the next taken the cycle after the last result
//   word is loaded; the single-port heap memory (one access per cycle) paces the scan.
// Reset: async active low; heap count goes to zero, capacity to 32, no results held.
//   Heap memory is not cleared; only slots already written are ever read.
`timescale 1ns / 1ps

module max_heap_insert_find_core #(
	parameter int HEAP_DEPTH = mhif_pkg::HEAP_DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration write channel
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [mhif_pkg::CAP_W-1:0]        cfg_data,
	// command channel
	input  logic                              cmd_valid,
	output logic                              cmd_ready,
	input  logic [1:0]                        command,
	input  logic signed [mhif_pkg::KEY_W-1:0] key_value,
	// result channel
	output logic                              rsp_valid,
	input  logic                              rsp_ready,
	output mhif_pkg::status_t                 status,
	output logic signed [mhif_pkg::KEY_W-1:0] data_out,
	output logic                              last
);
	import mhif_pkg::*;

	localparam int AW = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
	localparam int CW = $clog2(HEAP_DEPTH + 1);
	localparam int XW = ((CW > CAP_W) ? CW : CAP_W) + 1;

	// heap memory, slot n at address n-1
	logic signed [KEY_W-1:0] mem [HEAP_DEPTH];
	logic signed [KEY_W-1:0] mem_rd_s1;
	logic                    rd_vld_s1;

	logic                    mem_re, mem_we;
	logic [AW-1:0]           mem_ra, mem_wa;
	logic signed [KEY_W-1:0] mem_wd;

	state_t                  state_q, state_nxt;
	cmd_t                    cmd_q;
	status_t                 resp_q;
	logic signed [KEY_W-1:0] key_q;
	logic [CAP_W-1:0]        cap_q;
	logic [CW-1:0]           cnt_q, idx_q, pos_q;

	logic                    rsp_vld_q, last_q;
	status_t                 status_q;
	logic signed [KEY_W-1:0] data_q;

	logic                    cmd_acc, out_free, out_load;
	logic                    full, scan_re, scan_hit, scan_miss;
	logic                    sift_top, parent_less, dump_last, ins_done;
	logic [CW-1:0]           pos_m1, parent_m1;

	assign cmd_ready = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign cmd_acc   = cmd_valid && cmd_ready;
	assign out_free  = !rsp_vld_q || rsp_ready;

	// full when count reaches capacity, capacity saturating at depth
	assign full = (XW'(cnt_q) >= XW'(cap_q)) || (cnt_q == CW'(HEAP_DEPTH));

	// scan pipeline: issue read of one slot, compare the registered read data with the key
	assign scan_re   = (state_q == S_SCAN) && (idx_q < cnt_q);
	assign scan_hit  = rd_vld_s1 && (mem_rd_s1 == key_q);
	assign scan_miss = !rd_vld_s1 && !(idx_q < cnt_q);

	assign pos_m1      = pos_q - CW'(1);
	assign parent_m1   = (pos_q >> 1) - CW'(1);
	assign sift_top    = (pos_q == CW'(1));
	assign parent_less = (mem_rd_s1 < key_q);
	assign dump_last   = (idx_q == cnt_q - CW'(1));
	assign ins_done    = ((state_q == S_SIFT_RD) && sift_top) ||
	                     ((state_q == S_SIFT_CMP) && !parent_less);

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (cmd_acc) begin
					case (cmd_t'(command))
						CMD_INSERT: state_nxt = full ? S_RESP : S_SCAN;
						CMD_FIND:   state_nxt = S_SCAN;
						CMD_DUMP:   state_nxt = (cnt_q == '0) ? S_RESP : S_DUMP_RD;
						default:    state_nxt = S_IDLE;
					endcase
				end
			end
			S_SCAN: begin
				if (scan_hit)
					state_nxt = S_RESP;
				else if (scan_miss)
					state_nxt = (cmd_q == CMD_INSERT) ? S_SIFT_RD : S_RESP;
			end
			S_SIFT_RD:  state_nxt = sift_top ? S_RESP : S_SIFT_CMP;
			S_SIFT_CMP: state_nxt = parent_less ? S_SIFT_RD : S_RESP;
			S_DUMP_RD:  state_nxt = S_DUMP_OUT;
			S_DUMP_OUT: begin
				if (out_free)
					state_nxt = dump_last ? S_IDLE : S_DUMP_RD;
			end
			S_RESP: begin
				if (out_free)
					state_nxt = S_IDLE;
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	// memory and result-register controls
	always_comb begin
		mem_re   = 1'b0;
		mem_we   = 1'b0;
		mem_ra   = idx_q[AW-1:0];
		mem_wa   = pos_m1[AW-1:0];
		mem_wd   = key_q;
		out_load = 1'b0;
		case (state_q)
			S_SCAN: mem_re = scan_re;
			S_SIFT_RD: begin
				if (sift_top) begin
					mem_we = 1'b1;
				end else begin
					mem_re = 1'b1;
					mem_ra = parent_m1[AW-1:0];
				end
			end
			S_SIFT_CMP: begin
				mem_we = 1'b1;
				mem_wd = parent_less ? mem_rd_s1 : key_q;
			end
			S_DUMP_RD:  mem_re = 1'b1;
			S_DUMP_OUT: out_load = out_free;
			S_RESP:     out_load = out_free;
			default: begin
				mem_re = 1'b0;
			end
		endcase
	end

	// heap memory, one access per cycle, registered read
	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_wa] <= mem_wd;
		if (mem_re)
			mem_rd_s1 <= mem[mem_ra];
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cap_q     <= CAP_RESET;
			cnt_q     <= '0;
			idx_q     <= '0;
			pos_q     <= '0;
			rd_vld_s1 <= 1'b0;
			rsp_vld_q <= 1'b0;
		end else begin
			state_q   <= state_nxt;
			rd_vld_s1 <= scan_re;
			if (cfg_valid && cfg_ready)
				cap_q <= cfg_data;
			if (cmd_acc)
				idx_q <= '0;
			else if (scan_re || ((state_q == S_DUMP_OUT) && out_free))
				idx_q <= idx_q + CW'(1);
			// sift starts at the new last slot and climbs one level per pass
			if ((state_q == S_SCAN) && !scan_hit && scan_miss)
				pos_q <= cnt_q + CW'(1);
			else if ((state_q == S_SIFT_CMP) && parent_less)
				pos_q <= pos_q >> 1;
			if (ins_done)
				cnt_q <= cnt_q + CW'(1);
			if (out_load)
				rsp_vld_q <= 1'b1;
			else if (rsp_ready)
				rsp_vld_q <= 1'b0;
		end
	end

	// command payload and pending status
	always_ff @(posedge clk) begin
		if (cmd_acc) begin
			key_q  <= key_value;
			cmd_q  <= cmd_t'(command);
			resp_q <= (cmd_t'(command) == CMD_DUMP) ? ST_EMPTY : ST_FULL;
		end else if ((state_q == S_SCAN) && scan_hit) begin
			resp_q <= (cmd_q == CMD_INSERT) ? ST_DUP : ST_FOUND;
		end else if ((state_q == S_SCAN) && scan_miss) begin
			resp_q <= ST_MISSING;
		end else if (ins_done) begin
			resp_q <= ST_INSERTED;
		end
	end

	// result word register
	always_ff @(posedge clk) begin
		if (out_load) begin
			if (state_q == S_DUMP_OUT) begin
				status_q <= ST_ELEM;
				data_q   <= mem_rd_s1;
				last_q   <= dump_last;
			end else begin
				status_q <= resp_q;
				data_q   <= (resp_q == ST_EMPTY) ? '0 : key_q;
				last_q   <= 1'b1;
			end
		end
	end

	assign rsp_valid = rsp_vld_q;
	assign status    = status_q;
	assign data_out  = data_q;
	assign last      = last_q;

endmodule

>>> sim/tb.sv
// Self-checking testbench for the max-heap insert/find core: directed, capacity and random traffic.
`timescale 1ns / 1ps

module tb;
	import mhif_pkg::*;

	localparam int DEPTH = 32;
	// idle time after the last expected word, for the core to settle
	localparam int SETTLE_CYCLES = 48;
	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
	localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7fff_ffff;

	// one expected result word
	typedef struct {
		status_t                 st;
		logic signed [KEY_W-1:0] data;
		logic                    lst;
	} heap_word_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    cfg_valid = 1'b0;
	logic                    cfg_ready;
	logic [CAP_W-1:0]        cfg_data = '0;
	logic                    cmd_valid = 1'b0;
	logic                    cmd_ready;
	logic [1:0]              command = '0;
	logic signed [KEY_W-1:0] key_value = '0;
	logic                    rsp_valid;
	logic                    rsp_ready = 1'b0;
	status_t                 status;
	logic signed [KEY_W-1:0] data_out;
	logic                    last;

	// predictor state
	logic signed [KEY_W-1:0] heap_keys [1:DEPTH];
	int                      heap_size = 0;
	int                      cap_reg = 32;
	heap_word_t              expected_words [$];
	logic signed [KEY_W-1:0] key_pool [$];

	int mismatch_count = 0;
	bit send_steady = 1'b0;
	bit rsp_steady = 1'b0;
	int stall_left = 0;

	max_heap_insert_find_core #(
		.HEAP_DEPTH(DEPTH)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.command  (command),
		.key_value(key_value),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.status   (status),
		.data_out (data_out),
		.last     (last)
	);

	always #6 clk = ~clk;

	// mostly short gaps, now and then a long one
	function automatic int idle_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45)
			return 0;
		if (r < 80)
			return $urandom_range(1, 2);
		if (r < 95)
			return $urandom_range(3, 8);
		return $urandom_range(15, 40);
	endfunction

	function automatic void push_word(status_t st, logic signed [KEY_W-1:0] d, logic lst);
		heap_word_t w;
		w.st = st;
		w.data = d;
		w.lst = lst;
		expected_words.push_back(w);
	endfunction

	// heap behavior for one accepted command word
	function automatic void predict_heap(logic [1:0] c, logic signed [KEY_W-1:0] k);
		int  eff_cap;
		int  i;
		bit  hit;
		eff_cap = (cap_reg > DEPTH) ? DEPTH : cap_reg;
		hit = 1'b0;
		for (i = 1; i <= heap_size; i++)
			if (heap_keys[i] == k)
				hit = 1'b1;
		case (c)
			CMD_INSERT: begin
				if (heap_size >= eff_cap) begin
					push_word(ST_FULL, k, 1'b1);
				end else if (hit) begin
					push_word(ST_DUP, k, 1'b1);
				end else begin
					// sift up: smaller parents move down one level
					heap_size++;
					i = heap_size;
					while (i > 1 && heap_keys[i / 2] < k) begin
						heap_keys[i] = heap_keys[i / 2];
						i = i / 2;
					end
					heap_keys[i] = k;
					push_word(ST_INSERTED, k, 1'b1);
				end
			end
			CMD_FIND:
				push_word(hit ? ST_FOUND : ST_MISSING, k, 1'b1);
			CMD_DUMP: begin
				if (heap_size == 0)
					push_word(ST_EMPTY, '0, 1'b1);
				else
					for (i = 1; i <= heap_size; i++)
						push_word(ST_ELEM, heap_keys[i], i == heap_size);
			end
			default: ;
		endcase
	endfunction

	task automatic report_mismatch(input string what, input logic [KEY_W-1:0] got,
			input logic [KEY_W-1:0] want);
		$display("%0t: mismatch on %s: got 'h%08h, expected 'h%08h", $realtime, what, got, want);
		mismatch_count++;
	endtask

	// send one command word, predict it at acceptance
	task automatic send_word(input logic [1:0] c, input logic signed [KEY_W-1:0] k);
		int gap;
		gap = send_steady ? 0 : idle_gap();
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_valid <= 1'b1;
		command <= c;
		key_value <= k;
		do @(posedge clk); while (!cmd_ready);
		predict_heap(c, k);
		if (c == CMD_INSERT || c == CMD_FIND)
			key_pool.push_back(k);
	endtask

	// stop sending, let every expected word come back and the core settle
	task automatic drain_results();
		cmd_valid <= 1'b0;
		while (expected_words.size() > 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_capacity(input logic [CAP_W-1:0] v);
		drain_results();
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		cap_reg = int'(v);
	endtask

	function automatic logic signed [KEY_W-1:0] pick_key();
		int r;
		r = $urandom_range(0, 9);
		if (r >= 7 && key_pool.size() > 0)
			return key_pool[$urandom_range(0, key_pool.size() - 1)];
		if (r == 6) begin
			case ($urandom_range(0, 3))
				0: return KEY_MIN;
				1: return KEY_MAX;
				2: return '0;
				default: return -1;
			endcase
		end
		if (r >= 4)
			return $signed($urandom_range(0, 16)) - 8;
		return $signed($urandom);
	endfunction

	// dump and find on a heap with nothing stored
	task automatic test_empty_heap();
		send_word(CMD_DUMP, '0);
		send_word(CMD_FIND, '0);
	endtask

	// extreme keys, sift to the root, duplicate, find hit and miss, unused command
	task automatic test_extreme_keys();
		send_word(CMD_INSERT, '0);
		send_word(CMD_INSERT, KEY_MAX);
		send_word(CMD_INSERT, KEY_MIN);
		send_word(CMD_INSERT, -1);
		send_word(CMD_INSERT, 1);
		send_word(CMD_INSERT, KEY_MAX);
		send_word(CMD_FIND, KEY_MIN);
		send_word(CMD_FIND, 5);
		send_word(CMD_UNUSED, -1);
		send_word(CMD_DUMP, KEY_MAX);
	endtask

	// zero capacity, saturation above depth, capacity below and at the count
	task automatic test_capacity_limits();
		write_capacity(6'd0);
		send_word(CMD_INSERT, 7);
		send_word(CMD_FIND, 1);
		write_capacity(6'd63);
		send_word(CMD_INSERT, 7);
		write_capacity(6'd1);
		send_word(CMD_INSERT, 8);
		send_word(CMD_INSERT, KEY_MAX);   // full wins over duplicate
		send_word(CMD_DUMP, '0);
		write_capacity(6'd6);
		send_word(CMD_INSERT, 9);
		write_capacity(6'd7);
		send_word(CMD_INSERT, 9);
		send_word(CMD_INSERT, 10);
	endtask

	// random phases, each under its own capacity; the heap fills along the way
	task automatic test_random_traffic();
		logic [CAP_W-1:0] caps [6];
		int               ph;
		int               sent;
		int               r;
		logic [1:0]       c;
		caps[0] = 6'd14;
		caps[1] = 6'd24;
		caps[2] = 6'd0;
		caps[3] = 6'd63;
		caps[4] = CAP_W'($urandom_range(1, 63));
		caps[5] = 6'd32;
		for (ph = 0; ph < 6; ph++) begin
			write_capacity(caps[ph]);
			send_steady = ($urandom_range(0, 3) == 0);
			rsp_steady = ($urandom_range(0, 3) == 0);
			sent = 0;
			while (sent < 70) begin
				r = $urandom_range(0, 99);
				if (r < 45)
					c = CMD_INSERT;
				else if (r < 85)
					c = CMD_FIND;
				else if (r < 95)
					c = CMD_DUMP;
				else
					c = CMD_UNUSED;
				send_word(c, pick_key());
				if (c != CMD_UNUSED)
					sent++;
			end
		end
		send_steady = 1'b0;
		rsp_steady = 1'b0;
	endtask

	// result side stalls
	always @(posedge clk) begin
		if (stall_left == 0 && !rsp_steady && $urandom_range(0, 2) == 0)
			stall_left = idle_gap();
		if (stall_left > 0) begin
			stall_left--;
			rsp_ready <= 1'b0;
		end else begin
			rsp_ready <= 1'b1;
		end
	end

	// compare each accepted result word with the oldest expectation
	always @(posedge clk) begin : check_words
		heap_word_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (expected_words.size() == 0) begin
				report_mismatch("word with none expected", data_out, '0);
			end else begin
				want = expected_words.pop_front();
				if (status !== want.st)
					report_mismatch("status", KEY_W'(status), KEY_W'(want.st));
				if (data_out !== want.data)
					report_mismatch("data_out", data_out, want.data);
				if (last !== want.lst)
					report_mismatch("last", KEY_W'(last), KEY_W'(want.lst));
			end
		end
	end

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_heap();
		test_extreme_keys();
		test_capacity_limits();
		test_random_traffic();
		drain_results();
		if (mismatch_count == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

	initial begin
		#40_000_000;
		$display("tb failed");
		$finish;
	end

endmodule
